// ===== rtl/ucrm_pkg.sv =====
// Shared types and constants for the calibrated ultrasonic range arithmetic block.
// Used by the divider cells, the divider chain, the top level and the simulation files.
`default_nettype none
package ucrm_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_RANGE = 2'd0,
    OP_MAXR  = 2'd1,
    OP_IVAL  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // Register indexes (byte address is 4 * index)
  localparam logic REG_RTC = 1'b0;
  localparam logic REG_SF  = 1'b1;

  localparam int DW           = 32;  // dividend / quotient width
  localparam int DEN_SHIFT    = 11;  // range divisor scaling
  localparam int CEIL_SHIFT   = 14;  // calibration ceiling by 0x4000
  localparam int PERIOD_SHIFT = 11;  // samples per period step (2048)
  localparam logic [31:0] CEIL_ADD = 32'h0000_3FFF;

  // Side data that travels with an item down the divider chains
  typedef struct packed {
    op_t         op;
    logic [15:0] arg;
    logic        nt;
    logic        flt;
    logic [7:0]  per;
    logic [31:0] res;
  } ctl_t;

  // One result item
  typedef struct packed {
    logic [31:0] result_value;
    logic [7:0]  period_count;
    logic        no_target;
    logic        fault;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/ucrm_if.sv =====
// Valid/ready channels for requests and results of the range arithmetic block.
// No dependencies.
`default_nettype none
interface ucrm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] operand;
  modport source (output valid, req_type, operand, input ready);
  modport sink (input valid, req_type, operand, output ready);
endinterface

interface ucrm_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [7:0]  period_count;
  logic        no_target;
  logic        fault;
  modport source (output valid, result_value, period_count, no_target, fault, input ready);
  modport sink (input valid, result_value, period_count, no_target, fault, output ready);
endinterface
`default_nettype wire

// ===== rtl/ucrm_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and registers the result.
// Depends on ucrm_pkg.
`default_nettype none
module ucrm_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            v_in,
  input  wire ucrm_pkg::ctl_t  ctl_in,
  input  wire logic [31:0]     word_in,
  input  wire logic [31:0]     rem_in,
  input  wire logic [31:0]     div_in,
  output logic                 v_out,
  output ucrm_pkg::ctl_t       ctl_out,
  output logic [31:0]          word_out,
  output logic [31:0]          rem_out,
  output logic [31:0]          div_out
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_in, word_in[31]};
    diff  = trial - {1'b0, div_in};
    ge    = (trial >= {1'b0, div_in});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  // word holds the unused dividend bits above and quotient bits below
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out  <= ctl_in;
      word_out <= {word_in[30:0], ge};
      rem_out  <= ge ? diff[31:0] : trial[31:0];
      div_out  <= div_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ucrm_div_chain.sv =====
// Row of 32 division cells: a 32-bit by 32-bit unsigned divider, one item per cycle while en is high.
// Depends on ucrm_pkg and ucrm_div_cell.
`default_nettype none
module ucrm_div_chain (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire ucrm_pkg::ctl_t  in_ctl,
  input  wire logic [31:0]     in_num,
  input  wire logic [31:0]     in_div,
  output logic                 out_v,
  output ucrm_pkg::ctl_t       out_ctl,
  output logic [31:0]          out_quo
);

  logic           v    [0:ucrm_pkg::DW];
  ucrm_pkg::ctl_t ctl  [0:ucrm_pkg::DW];
  logic [31:0]    word [0:ucrm_pkg::DW];
  logic [31:0]    rem  [0:ucrm_pkg::DW];
  logic [31:0]    dv   [0:ucrm_pkg::DW];

  assign v[0]    = in_v;
  assign ctl[0]  = in_ctl;
  assign word[0] = in_num;
  assign rem[0]  = '0;
  assign dv[0]   = in_div;

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < ucrm_pkg::DW; i++) begin : g_cell
    ucrm_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .v_in     (v[i]),
      .ctl_in   (ctl[i]),
      .word_in  (word[i]),
      .rem_in   (rem[i]),
      .div_in   (dv[i]),
      .v_out    (v[i+1]),
      .ctl_out  (ctl[i+1]),
      .word_out (word[i+1]),
      .rem_out  (rem[i+1]),
      .div_out  (dv[i+1])
    );
  end

  assign out_v   = v[ucrm_pkg::DW];
  assign out_ctl = ctl[ucrm_pkg::DW];
  assign out_quo = word[ucrm_pkg::DW];

endmodule
`default_nettype wire

// ===== rtl/ultrasonic_calibrated_range_math.sv =====
// Top level of the calibrated ultrasonic range arithmetic block.
// Depends on ucrm_pkg, ucrm_if (ucrm_req_if, ucrm_res_if) and ucrm_div_chain.
//
// Takes one request per clock while the skid buffer is empty and returns one
// result per request, in order. Each item passes an input register, a multiply
// stage, a 32-cell divider chain, a post-processing stage, a second 32-cell
// divider chain and the output register.
// The two divider chains carry one item per cycle while the skid buffer is empty,
// since they resolve one quotient bit per cell and hold a different item in
// every cell. A two-entry output buffer lets requests flow while a result waits.
// Calibration registers rtc_count (0x0) and tof_scale (0x4) are written over
// the APB port and must only change while no request is in flight.
`default_nettype none
module ultrasonic_calibrated_range_math #(
  parameter int SOUND_SPEED_MPS = 343,
  parameter int CAL_PULSE_MS    = 100,
  parameter int MAX_SAMPLES     = 450
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ucrm_req_if.sink         req,
  ucrm_res_if.source       res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [31:0] KSP   = 32'(SOUND_SPEED_MPS * CAL_PULSE_MS);
  localparam logic [31:0] KSPM1 = 32'(SOUND_SPEED_MPS * CAL_PULSE_MS - 1);
  localparam logic [31:0] PULSE = 32'(CAL_PULSE_MS);
  localparam logic [15:0] MAXS  = 16'(MAX_SAMPLES);

  // ---------------- configuration registers ----------------
  logic [15:0] rtc_count;
  logic [15:0] tof_scale;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rtc_count <= '0;
      tof_scale <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ucrm_pkg::REG_RTC) begin
        rtc_count <= pwdata[15:0];
      end else begin
        tof_scale <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ucrm_pkg::REG_RTC) prdata = {16'b0, rtc_count};
    else prdata = {16'b0, tof_scale};
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic           skid_v;
  ucrm_pkg::res_t skid;
  logic           out_v;
  ucrm_pkg::res_t out_r;

  assign en        = !skid_v;
  assign req.ready = en;

  // ---------------- stage A: input register and products ----------------
  logic           a_v;
  ucrm_pkg::op_t  a_op;
  logic [15:0]    a_arg;
  logic           a_nt;
  logic [31:0]    a_pcal;
  logic [31:0]    a_pb;
  ucrm_pkg::op_t  req_op;
  logic [31:0]    mul_a;
  logic [47:0]    mul_b;

  always_comb begin
    req_op = ucrm_pkg::op_t'(req.req_type);
    mul_a  = (req_op == ucrm_pkg::OP_IVAL) ? {16'b0, rtc_count} : KSP;
    mul_b  = 48'(mul_a) * 48'(req.operand);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op   <= req_op;
      a_arg  <= req.operand;
      a_nt   <= (req_op == ucrm_pkg::OP_RANGE) &&
                (req.operand == 16'hFFFF || tof_scale == 16'd0);
      a_pcal <= 32'(rtc_count) * 32'(tof_scale);
      a_pb   <= mul_b[31:0];
    end
  end

  // ---------------- stage B: divider operands ----------------
  logic           b_v;
  ucrm_pkg::ctl_t b_ctl;
  logic [31:0]    b_num;
  logic [31:0]    b_div;
  logic [31:0]    ceil_sum;
  logic [17:0]    s1;
  logic [33:0]    mp;
  logic [31:0]    den;
  ucrm_pkg::ctl_t b_ctl_next;
  logic [31:0]    b_num_next;
  logic [31:0]    b_div_next;

  always_comb begin
    ceil_sum = a_pcal + ucrm_pkg::CEIL_ADD;
    s1       = ceil_sum[31:ucrm_pkg::CEIL_SHIFT];
    mp       = 34'(s1) * 34'(a_arg);
    den      = a_pcal >> ucrm_pkg::DEN_SHIFT;
    b_ctl_next     = '0;
    b_ctl_next.op  = a_op;
    b_ctl_next.arg = a_arg;
    b_num_next = '0;
    b_div_next = '0;
    case (a_op)
      ucrm_pkg::OP_RANGE: begin
        b_ctl_next.nt  = a_nt;
        b_ctl_next.flt = !a_nt && (den == 32'd0);
        b_num_next     = a_pb;
        b_div_next     = den;
      end
      ucrm_pkg::OP_MAXR: begin
        b_num_next = mp[31:0] + KSPM1;
        b_div_next = KSP;
      end
      ucrm_pkg::OP_IVAL: begin
        b_num_next = a_pb;
        b_div_next = PULSE;
      end
      default: begin
        b_ctl_next.flt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl <= b_ctl_next;
      b_num <= b_num_next;
      b_div <= b_div_next;
    end
  end

  // ---------------- first divider ----------------
  logic           d1_v;
  ucrm_pkg::ctl_t d1_ctl;
  logic [31:0]    d1_q;

  ucrm_div_chain u_div1 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (b_v),
    .in_ctl  (b_ctl),
    .in_num  (b_num),
    .in_div  (b_div),
    .out_v   (d1_v),
    .out_ctl (d1_ctl),
    .out_quo (d1_q)
  );

  // ---------------- stage C: post-processing ----------------
  logic           c_v;
  ucrm_pkg::ctl_t c_ctl;
  logic [31:0]    c_num;
  logic [31:0]    c_div;
  ucrm_pkg::ctl_t c_ctl_next;
  logic [15:0]    ms;
  logic [15:0]    mc;
  logic [21:0]    p;

  always_comb begin
    c_ctl_next = d1_ctl;
    ms = (d1_q > 32'h0000_FFFF) ? 16'd0 : {d1_q[14:0], 1'b0};
    mc = (ms > MAXS) ? MAXS : ms;
    p  = (d1_ctl.arg != 16'd0) ? 22'(d1_q >> ucrm_pkg::PERIOD_SHIFT) + 22'd1 : 22'd0;
    case (d1_ctl.op)
      ucrm_pkg::OP_RANGE: begin
        c_ctl_next.res = (d1_ctl.nt || d1_ctl.flt) ? 32'd0 : d1_q;
      end
      ucrm_pkg::OP_MAXR: begin
        c_ctl_next.res = {17'b0, mc[15:1]};
      end
      ucrm_pkg::OP_IVAL: begin
        c_ctl_next.res = '0;
        if (p > 22'd255) begin
          c_ctl_next.flt = 1'b1;
          c_ctl_next.per = '0;
        end else begin
          c_ctl_next.per = p[7:0];
        end
      end
      default: begin
        c_ctl_next.res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctl <= c_ctl_next;
      c_num <= d1_q;
      c_div <= {24'b0, p[7:0]};
    end
  end

  // ---------------- second divider: tick interval ----------------
  logic           d2_v;
  ucrm_pkg::ctl_t d2_ctl;
  logic [31:0]    d2_q;
  ucrm_pkg::res_t tail;

  ucrm_div_chain u_div2 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (c_v),
    .in_ctl  (c_ctl),
    .in_num  (c_num),
    .in_div  (c_div),
    .out_v   (d2_v),
    .out_ctl (d2_ctl),
    .out_quo (d2_q)
  );

  always_comb begin
    tail.result_value = (d2_ctl.op == ucrm_pkg::OP_IVAL && d2_ctl.per != 8'd0 &&
                         !d2_ctl.flt) ? d2_q : d2_ctl.res;
    tail.period_count = d2_ctl.per;
    tail.no_target    = d2_ctl.nt;
    tail.fault        = d2_ctl.flt;
  end

  // ---------------- output register and skid buffer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (res.ready || !out_v) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= d2_v;
      end
    end else if (d2_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.ready || !out_v) begin
      out_r <= skid_v ? skid : tail;
    end else if (en) begin
      skid <= tail;
    end
  end

  assign res.valid        = out_v;
  assign res.result_value = out_r.result_value;
  assign res.period_count = out_r.period_count;
  assign res.no_target    = out_r.no_target;
  assign res.fault        = out_r.fault;

  // ---------------- assertions ----------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.no_target && res.fault))
    else $error("no_target and fault raised together");

  a_period_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.period_count != 8'd0) |-> (!res.fault && !res.no_target))
    else $error("period count given with a flag");

  a_skid_holds_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid buffer full while output empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_v && !res.ready))
    else $error("skid buffer filled without an output stall");

endmodule
`default_nettype wire

// ===== sim/range_math_checker.sv =====
// Result checker for the calibrated ultrasonic range arithmetic block.
// Depends on ucrm_pkg and the request/result channel interfaces in ucrm_if.
// Mirrors the calibration registers from the APB port and predicts each result.
`default_nettype none
module range_math_checker #(
  parameter int SOUND_SPEED_MPS = 343,
  parameter int CAL_PULSE_MS    = 100,
  parameter int MAX_SAMPLES     = 450
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ucrm_req_if              req,
  ucrm_res_if              res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatches,
  output int               outstanding,
  output int               results_seen
);

  logic [15:0]    rtc_mirror;
  logic [15:0]    scale_mirror;
  ucrm_pkg::res_t expected_results[$];

  // Ceiling division with the sum wrapping at 32 bits
  function automatic logic [31:0] ceil_wrap(logic [31:0] n, logic [31:0] d);
    logic [31:0] t;
    if (d == 0) return 0;
    t = n + (d - 32'd1);
    return t / d;
  endfunction

  // Expected result item for one request under the current calibration
  function automatic ucrm_pkg::res_t calc_conversion(ucrm_pkg::op_t op, logic [15:0] arg);
    ucrm_pkg::res_t r;
    logic [31:0]    num, den, s, p, cal;
    r   = '0;
    cal = 32'(rtc_mirror) * 32'(scale_mirror);
    case (op)
      ucrm_pkg::OP_RANGE: begin
        if (arg == 16'hFFFF || scale_mirror == 0) begin
          r.no_target = 1'b1;
        end else begin
          num = 32'(SOUND_SPEED_MPS * CAL_PULSE_MS) * 32'(arg);
          den = cal >> ucrm_pkg::DEN_SHIFT;
          if (den == 0) r.fault = 1'b1;
          else r.result_value = num / den;
        end
      end
      ucrm_pkg::OP_MAXR: begin
        s = ceil_wrap(cal, 32'h4000);
        s = ceil_wrap(s * 32'(arg), 32'(CAL_PULSE_MS * SOUND_SPEED_MPS));
        if (s > 32'hFFFF) s = 0;
        else s = (s * 2) & 32'hFFFF;
        if (s > MAX_SAMPLES) s = MAX_SAMPLES;
        r.result_value = s / 2;
      end
      ucrm_pkg::OP_IVAL: begin
        s = (32'(rtc_mirror) * 32'(arg)) / CAL_PULSE_MS;
        p = (arg != 0) ? s / 2048 + 1 : 0;
        if (p > 255) begin
          r.fault = 1'b1;
        end else begin
          r.period_count = p[7:0];
          r.result_value = (p != 0) ? s / p : 0;
        end
      end
      default: r.fault = 1'b1;
    endcase
    return r;
  endfunction

  // Register mirror, prediction on acceptance, comparison on delivery
  always @(posedge clk) begin
    ucrm_pkg::res_t got, want;
    if (rst) begin
      rtc_mirror   <= '0;
      scale_mirror <= '0;
      mismatches   <= 0;
      results_seen <= 0;
      outstanding  <= 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(4 * ucrm_pkg::REG_RTC)) rtc_mirror <= pwdata[15:0];
        else if (paddr == 3'(4 * ucrm_pkg::REG_SF)) scale_mirror <= pwdata[15:0];
      end
      if (req.valid && req.ready)
        expected_results.push_back(
          calc_conversion(ucrm_pkg::op_t'(req.req_type), req.operand));
      if (res.valid && res.ready) begin
        results_seen <= results_seen + 1;
        got = '{res.result_value, res.period_count, res.no_target, res.fault};
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result item %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("mismatch: expected %p, got %p", want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= expected_results.size();
    end
  end

  final_check: assert property (@(posedge clk) 1);
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Stimulus and verdict for the calibrated ultrasonic range arithmetic block.
// Depends on ucrm_pkg, ucrm_if, the block itself and range_math_checker.
// Runs calibration phases with directed and random requests under varied idling.
`default_nettype none
module testbench;

  localparam int LATENCY = 68;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          mismatches, outstanding, results_seen;
  int          send_idle_pct, recv_idle_pct;
  int          sent;

  ucrm_req_if req ();
  ucrm_res_if res ();

  ultrasonic_calibrated_range_math i_dut (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  range_math_checker i_checker (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen)
  );

  always #10 clk = ~clk;

  // Receiver stalls at random
  always @(posedge clk) begin
    res.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("ultrasonic_calibrated_range_math test failed");
    $finish;
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Present one request, idling first at random, and wait for its acceptance
  task automatic send_request(ucrm_pkg::op_t op, logic [15:0] arg);
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req.valid    <= 1'b1;
    req.req_type <= op;
    req.operand  <= arg;
    do @(posedge clk); while (!req.ready);
    sent++;
    // Idling schedule follows the item count
    if (sent == 420) begin
      send_idle_pct = 64;
      recv_idle_pct = 38;
    end else if (sent == 840) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // Hold off until every result is back, then reprogram the calibration
  task automatic drain_and_calibrate(logic [15:0] rtc, logic [15:0] sf);
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    reg_write(3'(4 * ucrm_pkg::REG_RTC), {16'($urandom_range(65535)), rtc});
    reg_write(3'(4 * ucrm_pkg::REG_SF), {16'($urandom_range(65535)), sf});
  endtask

  function automatic logic [15:0] random_operand();
    case ($urandom_range(5))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(3000));
      2: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0]   rtc_set[8];
    logic [15:0]   sf_set[8];
    logic [15:0]   edge_args[6];
    ucrm_pkg::op_t op;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    req.valid    <= 1'b0;
    req.req_type <= ucrm_pkg::OP_RANGE;
    req.operand  <= '0;
    send_idle_pct = 38;
    recv_idle_pct = 64;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Calibration settings: reset values, a zero range divisor, extremes, mid values
    rtc_set = '{16'd0, 16'd1, 16'hFFFF, 16'd3200, 16'hFFFF, 16'd0, 16'($urandom), 16'($urandom)};
    sf_set  = '{16'd0, 16'd1, 16'hFFFF, 16'd4000, 16'd0, 16'hFFFF, 16'($urandom), 16'($urandom)};
    edge_args = '{16'd0, 16'd1, 16'h8000, 16'd1000, 16'hFFFE, 16'hFFFF};

    for (int ph = 0; ph < 8; ph++) begin
      // the first phase keeps the reset calibration
      if (ph != 0) drain_and_calibrate(rtc_set[ph], sf_set[ph]);
      // directed: range, maximum-range and interval requests against the operand extremes, then one bad request
      if (ph < 4) begin
        foreach (edge_args[k]) begin
          send_request(ucrm_pkg::OP_RANGE, edge_args[k]);
          send_request(ucrm_pkg::OP_MAXR, edge_args[k]);
          send_request(ucrm_pkg::OP_IVAL, edge_args[k]);
        end
        send_request(ucrm_pkg::OP_BAD, 16'h5A5A);
      end
      for (int n = 0; n < 147; n++) begin
        op = ucrm_pkg::op_t'($urandom_range(99) < 3 ? 3 : $urandom_range(2));
        send_request(op, random_operand());
      end
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d requests over 8 calibration settings, %0d results checked",
             sent, results_seen);
    $display("all request types, operand extremes and three idling regimes exercised");
    if (mismatches == 0) begin
      $display("ultrasonic_calibrated_range_math test passed");
    end else begin
      $display("ultrasonic_calibrated_range_math test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
